### hdl/sntc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sntc_pkg: shared definitions for the saturating numeric type converter
// Type codes, register indexes, width helpers and the stage records that
// travel between the unpack, align and pack parts of the pipeline.
// ---------------------------------------------------------------------------
package sntc_pkg;

    localparam logic [3:0] TY_I8  = 4'd0;
    localparam logic [3:0] TY_U8  = 4'd1;
    localparam logic [3:0] TY_I16 = 4'd2;
    localparam logic [3:0] TY_U16 = 4'd3;
    localparam logic [3:0] TY_I32 = 4'd4;
    localparam logic [3:0] TY_U32 = 4'd5;
    localparam logic [3:0] TY_I64 = 4'd6;
    localparam logic [3:0] TY_U64 = 4'd7;
    localparam logic [3:0] TY_F32 = 4'd8;
    localparam logic [3:0] TY_F64 = 4'd9;

    localparam logic [1:0] CFG_QUERY = 2'd0;
    localparam logic [1:0] CFG_STORE = 2'd1;
    localparam logic [1:0] CFG_DIR   = 2'd2;

    function automatic logic [6:0] type_width(input logic [3:0] t);
        logic [6:0] w;
        case (t)
            TY_I8, TY_U8:   w = 7'd8;
            TY_I16, TY_U16: w = 7'd16;
            TY_I32, TY_U32: w = 7'd32;
            TY_F32:         w = 7'd32;
            default:        w = 7'd64;
        endcase
        return w;
    endfunction

    function automatic logic type_signed(input logic [3:0] t);
        logic s;
        case (t)
            TY_I8, TY_I16, TY_I32, TY_I64, TY_F32, TY_F64: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] width_mask(input logic [6:0] w);
        logic [63:0] m;
        if (w >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << w) - 64'd1;
        end
        return m;
    endfunction

    // Value is mant * 2^(exp-63) once normalised.
    typedef struct packed {
        logic               fixed;
        logic [63:0]        fixed_bits;
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [12:0] exp;
        logic [63:0]        mant;
        logic [51:0]        payload;
        logic [3:0]         dst;
        logic               last;
    } sntc_num_t;

    typedef struct packed {
        logic        fixed;
        logic [63:0] fixed_bits;
        logic        nan;
        logic        zero;
        logic        sign;
        logic [51:0] payload;
        logic [3:0]  dst;
        logic        last;
        logic        int_sat;
        logic [63:0] int_mag;
        logic        flt_ovf;
        logic [10:0] ebase;
        logic [63:0] q;
        logic        g;
        logic        st;
    } sntc_aln_t;

endpackage

### hdl/sntc_unpack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sntc_unpack: source decode
// Splits the source element into sign, magnitude and exponent, flags the
// special classes and settles pass-through and undefined type codes.
// ---------------------------------------------------------------------------
module sntc_unpack (
    input  logic [3:0]            src,
    input  logic [3:0]            dst,
    input  logic [63:0]           value_bits,
    input  logic                  last,
    output sntc_pkg::sntc_num_t   num
);
    import sntc_pkg::*;

    logic [6:0]  sw;
    logic [63:0] x;
    logic [63:0] xs;
    logic [63:0] mag;
    logic        sneg;
    logic [7:0]  e8;
    logic [22:0] f23;
    logic [10:0] e11;
    logic [51:0] f52;

    always_comb begin
        sw   = type_width(src);
        x    = value_bits & width_mask(sw);
        sneg = type_signed(src) && x[6'(sw - 7'd1)];
        xs   = sneg ? (x | ~width_mask(sw)) : x;
        mag  = sneg ? (~xs + 64'd1) : xs;
        e8   = x[30:23];
        f23  = x[22:0];
        e11  = x[62:52];
        f52  = x[51:0];

        num      = '0;
        num.dst  = dst;
        num.last = last;
        if (src == TY_F32) begin
            num.sign    = x[31];
            num.nan     = (e8 == 8'hFF) && (f23 != 23'd0);
            num.inf     = (e8 == 8'hFF) && (f23 == 23'd0);
            num.zero    = (e8 == 8'd0) && (f23 == 23'd0);
            num.mant    = {(e8 != 8'd0), f23, 40'd0};
            num.exp     = (e8 == 8'd0) ? -13'sd126 : ($signed({5'd0, e8}) - 13'sd127);
            num.payload = {f23, 29'd0};
        end else if (src == TY_F64) begin
            num.sign    = x[63];
            num.nan     = (e11 == 11'h7FF) && (f52 != 52'd0);
            num.inf     = (e11 == 11'h7FF) && (f52 == 52'd0);
            num.zero    = (e11 == 11'd0) && (f52 == 52'd0);
            num.mant    = {(e11 != 11'd0), f52, 11'd0};
            num.exp     = (e11 == 11'd0) ? -13'sd1022 : ($signed({2'd0, e11}) - 13'sd1023);
            num.payload = f52;
        end else begin
            num.sign = sneg;
            num.zero = (mag == 64'd0);
            num.mant = mag;
            num.exp  = 13'sd63;
        end

        if ((src > TY_F64) || (dst > TY_F64)) begin
            num.fixed      = 1'b1;
            num.fixed_bits = 64'd0;
        end else if (src == dst) begin
            num.fixed      = 1'b1;
            num.fixed_bits = x;
        end
    end

endmodule

### hdl/sntc_align.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sntc_align: destination alignment
// Shifts the normalised magnitude into place for the destination: the
// integer part for integer types, or kept bits with guard and sticky for
// float types, together with the saturation flags.
// ---------------------------------------------------------------------------
module sntc_align (
    input  sntc_pkg::sntc_num_t num,
    output sntc_pkg::sntc_aln_t aln
);
    import sntc_pkg::*;

    logic [6:0]         dw;
    logic [6:0]         lim;
    logic               is32;
    logic signed [12:0] bias;
    logic signed [12:0] emin;
    logic [6:0]         prec_sh;
    logic               denorm;
    logic signed [13:0] dif;
    logic signed [13:0] rr;
    logic [6:0]         r7;
    logic [127:0]       ext;
    logic signed [12:0] ebt;

    always_comb begin
        dw  = type_width(num.dst);
        lim = type_signed(num.dst) ? (dw - 7'd1) : dw;

        is32    = (num.dst == TY_F32);
        bias    = is32 ? 13'sd127 : 13'sd1023;
        emin    = 13'sd1 - bias;
        prec_sh = is32 ? 7'd40 : 7'd11;
        denorm  = num.exp < emin;
        dif     = {emin[12], emin} - {num.exp[12], num.exp};
        rr      = $signed({7'd0, prec_sh}) + (denorm ? dif : 14'sd0);
        r7      = (rr > 14'sd127) ? 7'd127 : rr[6:0];
        ext     = {num.mant, 64'd0} >> r7;
        ebt     = num.exp + bias - 13'sd1;

        aln            = '0;
        aln.fixed      = num.fixed;
        aln.fixed_bits = num.fixed_bits;
        aln.nan        = num.nan;
        aln.zero       = num.zero;
        aln.sign       = num.sign;
        aln.payload    = num.payload;
        aln.dst        = num.dst;
        aln.last       = num.last;
        aln.int_sat    = num.inf || (!num.zero && (num.exp >= $signed({6'd0, lim})));
        // In range means 0 <= exp <= 63, where 63 - exp is the bitwise inverse.
        aln.int_mag    = (num.zero || (num.exp < 13'sd0) || (num.exp > 13'sd63)) ? 64'd0
                         : (num.mant >> (~num.exp[5:0]));
        aln.flt_ovf    = num.inf || (!num.zero && (num.exp > bias));
        aln.ebase      = denorm ? 11'd0 : ebt[10:0];
        aln.q          = ext[127:64];
        aln.g          = ext[63];
        aln.st         = |ext[62:0];
    end

endmodule

### hdl/sntc_pack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sntc_pack: result packing
// Rounds to nearest even and packs float results, or negates and saturates
// integer results, and applies the special cases.
// ---------------------------------------------------------------------------
module sntc_pack (
    input  sntc_pkg::sntc_aln_t aln,
    output logic [63:0]         bits
);
    import sntc_pkg::*;

    logic [63:0] mask;
    logic [63:0] smax;
    logic [63:0] smin;
    logic        inc;
    logic [63:0] sum32;
    logic [63:0] sum64;

    always_comb begin
        mask  = width_mask(type_width(aln.dst));
        smax  = mask >> 1;
        smin  = ~smax & mask;
        inc   = aln.g & (aln.st | aln.q[0]);
        // The hidden bit of q carries the exponent up by one, and a rounding
        // carry out of the fraction moves on into the exponent field.
        sum32 = ({53'd0, aln.ebase} << 23) + aln.q + {63'd0, inc};
        sum64 = ({53'd0, aln.ebase} << 52) + aln.q + {63'd0, inc};

        if (aln.fixed) begin
            bits = aln.fixed_bits;
        end else if (aln.dst == TY_F32) begin
            if (aln.nan) begin
                bits = {32'd0, aln.sign, 8'hFF, aln.payload[51:29] | 23'h400000};
            end else if (aln.zero) begin
                bits = {32'd0, aln.sign, 31'd0};
            end else if (aln.flt_ovf || (sum32[30:23] == 8'hFF)) begin
                bits = {32'd0, aln.sign, 31'h7F7FFFFF};
            end else begin
                bits = {32'd0, aln.sign, sum32[30:0]};
            end
        end else if (aln.dst == TY_F64) begin
            if (aln.nan) begin
                bits = {aln.sign, 11'h7FF, aln.payload | 52'h8000000000000};
            end else if (aln.zero) begin
                bits = {aln.sign, 63'd0};
            end else if (aln.flt_ovf || (sum64[62:52] == 11'h7FF)) begin
                bits = {aln.sign, 63'h7FEFFFFFFFFFFFFF};
            end else begin
                bits = {aln.sign, sum64[62:0]};
            end
        end else if (aln.nan) begin
            bits = 64'd0;
        end else if (type_signed(aln.dst)) begin
            if (aln.sign) begin
                bits = aln.int_sat ? smin : ((~aln.int_mag + 64'd1) & mask);
            end else begin
                bits = aln.int_sat ? smax : (aln.int_mag & mask);
            end
        end else begin
            if (aln.sign) begin
                bits = 64'd0;
            end else begin
                bits = aln.int_sat ? mask : (aln.int_mag & mask);
            end
        end
    end

endmodule

### hdl/saturating_numeric_type_converter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// saturating_numeric_type_converter: streaming numeric type conversion
// Converts one element per beat between two configured integer or float
// types, saturating out-of-range values.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_value_bits[63:0], s_last_in
//  m_       out        m_valid / m_ready    m_result_bits[63:0], m_last_out
//  cfg_     in         cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[3:0]
//
//  Five register stages: decode, leading-zero count, normalise, align,
//  round and pack. A beat enters every cycle unless every stage is full and stalled.
//  Each stage holds only while it is full and the stage after it holds, so
//  bubbles are squeezed out and a stalled output still lets beats enter.
//  Reset clears the stage valid bits and sets the types to i32 forward.
// ---------------------------------------------------------------------------
module saturating_numeric_type_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic        s_last_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_bits,
    output logic        m_last_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import sntc_pkg::*;

    logic [3:0]  query_type_reg;
    logic [3:0]  store_type_reg;
    logic        direction_reg;

    logic [4:0]  valid_reg;
    logic [4:0]  adv;

    sntc_num_t   dec_next;
    sntc_num_t   s1_reg;
    sntc_num_t   s2_reg;
    logic [6:0]  lz_next;
    logic [6:0]  lz_reg;
    sntc_num_t   norm_next;
    sntc_num_t   s3_reg;
    sntc_aln_t   aln_next;
    sntc_aln_t   s4_reg;
    logic [63:0] bits_next;
    logic [63:0] bits_reg;
    logic        last_reg;
    logic [3:0]  dst_reg;

    logic [3:0]  src;
    logic [3:0]  dst;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_type_reg <= TY_I32;
            store_type_reg <= TY_I32;
            direction_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_QUERY: query_type_reg <= cfg_data;
                CFG_STORE: store_type_reg <= cfg_data;
                CFG_DIR:   direction_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign src = direction_reg ? store_type_reg : query_type_reg;
    assign dst = direction_reg ? query_type_reg : store_type_reg;

    // A stage may load when it is empty or the stage after it moves on.
    always_comb begin
        adv[4] = !valid_reg[4] || m_ready;
        for (int k = 3; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready       = adv[0];
    assign m_valid       = valid_reg[4];
    assign m_result_bits = bits_reg;
    assign m_last_out    = last_reg;

    sntc_unpack u_unpack (
        .src        (src),
        .dst        (dst),
        .value_bits (s_value_bits),
        .last       (s_last_in),
        .num        (dec_next)
    );

    always_comb begin
        lz_next = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (s1_reg.mant[i]) begin
                lz_next = 7'(63 - i);
            end
        end
    end

    always_comb begin
        norm_next      = s2_reg;
        norm_next.mant = s2_reg.mant << lz_reg[5:0];
        norm_next.exp  = s2_reg.exp - $signed({6'd0, lz_reg});
    end

    sntc_align u_align (
        .num (s3_reg),
        .aln (aln_next)
    );

    sntc_pack u_pack (
        .aln  (s4_reg),
        .bits (bits_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 5'd0;
        end else begin
            if (adv[0]) valid_reg[0] <= s_valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
            if (adv[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_reg <= dec_next;
        end
        if (adv[1]) begin
            s2_reg <= s1_reg;
            lz_reg <= lz_next;
        end
        if (adv[2]) begin
            s3_reg <= norm_next;
        end
        if (adv[3]) begin
            s4_reg <= aln_next;
        end
        if (adv[4]) begin
            bits_reg <= bits_next;
            last_reg <= s4_reg.last;
            dst_reg  <= s4_reg.dst;
        end
    end

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (valid_reg == 5'b11111) && !m_ready)
        else $error("input stalled while the pipeline has room");

    a_byte_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((dst_reg == TY_I8) || (dst_reg == TY_U8))) |-> (m_result_bits[63:8] == 56'd0))
        else $error("byte result has upper bits set");

    a_word_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((dst_reg == TY_I32) || (dst_reg == TY_U32) || (dst_reg == TY_F32)))
        |-> (m_result_bits[63:32] == 32'd0))
        else $error("32-bit result has upper bits set");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the saturating numeric type converter
// Drives elements through the converter under many type pairs and both
// directions. An independent bit-level model predicts each converted element,
// and every output beat is checked in order against it. Both channels idle
// and stall at random, with a long output hold-off and a full drain pause.
// ---------------------------------------------------------------------------

class conv_scoreboard;
    typedef struct {
        logic [63:0] bits;
        logic        last;
    } conv_beat_t;

    conv_beat_t  awaited[$];
    logic [3:0]  query_ty;
    logic [3:0]  store_ty;
    logic        reverse;
    int          errors;
    int          checked;

    function new();
        query_ty = sntc_pkg::TY_I32;
        store_ty = sntc_pkg::TY_I32;
        reverse  = 1'b0;
        errors   = 0;
        checked  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] data);
        case (idx)
            sntc_pkg::CFG_QUERY: query_ty = data;
            sntc_pkg::CFG_STORE: store_ty = data;
            sntc_pkg::CFG_DIR:   reverse = data[0];
            default: ;
        endcase
    endfunction

    function int ty_bits(logic [3:0] t);
        case (t)
            sntc_pkg::TY_I8, sntc_pkg::TY_U8:   return 8;
            sntc_pkg::TY_I16, sntc_pkg::TY_U16: return 16;
            sntc_pkg::TY_I64, sntc_pkg::TY_U64,
            sntc_pkg::TY_F64:                   return 64;
            default:                            return 32;
        endcase
    endfunction

    function logic [63:0] lo_mask(int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function int top_bit(logic [63:0] m);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) p = i;
        end
        return p;
    endfunction

    // Rounds sign * m * 2^e2 to binary32 or binary64, nearest even,
    // saturating at the largest finite value.
    function logic [63:0] to_float(logic sgn, logic [63:0] m, int e2, logic dbl);
        int          frac, bias, ex, emin, qe, sh, fld;
        logic [63:0] k, bits, infp;
        logic        grd, stk;
        frac = dbl ? 52 : 23;
        bias = dbl ? 1023 : 127;
        infp = dbl ? 64'h7FF0_0000_0000_0000 : 64'h7F80_0000;
        if (m == 0) return dbl ? {sgn, 63'd0} : {32'd0, sgn, 31'd0};
        ex   = top_bit(m) + e2;
        emin = 1 - bias;
        qe   = ((ex > emin) ? ex : emin) - frac;
        sh   = qe - e2;
        if (sh <= 0) begin
            k = m << (-sh);
        end else if (sh > 64) begin
            k = 0;
        end else begin
            k   = (sh == 64) ? 64'd0 : (m >> sh);
            grd = m[sh-1];
            stk = (sh == 1) ? 1'b0 : ((m & ((64'd1 << (sh - 1)) - 64'd1)) != 0);
            if (grd && (stk || k[0])) k = k + 64'd1;
        end
        fld  = (ex >= emin) ? (ex + bias - 1) : 0;
        bits = (64'(fld) << frac) + k;
        if (bits >= infp) bits = infp - 64'd1;
        return dbl ? {sgn, bits[62:0]} : {32'd0, sgn, bits[30:0]};
    endfunction

    function logic [63:0] convert(logic [3:0] src, logic [3:0] dst, logic [63:0] raw);
        int                 sw, dw, e2, ex;
        logic [63:0]        x, mag, ip, dmask;
        logic [51:0]        payload;
        logic               is_flt, sgn, nan, inf, huge;
        logic signed [65:0] iv, smax, smin;
        if (src > sntc_pkg::TY_F64 || dst > sntc_pkg::TY_F64) return 0;
        sw    = ty_bits(src);
        dw    = ty_bits(dst);
        x     = raw & lo_mask(sw);
        dmask = lo_mask(dw);
        if (src == dst) return x;
        is_flt = 0; nan = 0; inf = 0; e2 = 0; payload = 0; iv = 0;
        if (src == sntc_pkg::TY_F32) begin
            is_flt  = 1;
            sgn     = x[31];
            payload = {x[22:0], 29'd0};
            nan     = (x[30:23] == 8'hFF) && (x[22:0] != 0);
            inf     = (x[30:23] == 8'hFF) && (x[22:0] == 0);
            mag     = (x[30:23] == 0) ? {41'd0, x[22:0]} : {40'd0, 1'b1, x[22:0]};
            e2      = (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
        end else if (src == sntc_pkg::TY_F64) begin
            is_flt  = 1;
            sgn     = x[63];
            payload = x[51:0];
            nan     = (x[62:52] == 11'h7FF) && (x[51:0] != 0);
            inf     = (x[62:52] == 11'h7FF) && (x[51:0] == 0);
            mag     = (x[62:52] == 0) ? {12'd0, x[51:0]} : {11'd0, 1'b1, x[51:0]};
            e2      = (x[62:52] == 0) ? -1074 : int'(x[62:52]) - 1075;
        end else begin
            if (src == sntc_pkg::TY_I8 || src == sntc_pkg::TY_I16 ||
                src == sntc_pkg::TY_I32 || src == sntc_pkg::TY_I64) begin
                sgn = x[sw-1];
                if (sgn) x = x | ~lo_mask(sw);
                iv  = $signed({{2{x[63]}}, x});
            end else begin
                sgn = 0;
                iv  = $signed({2'b00, x});
            end
            mag = sgn ? (~x + 64'd1) : x;
        end

        if (dst == sntc_pkg::TY_F32 || dst == sntc_pkg::TY_F64) begin
            if (dst == sntc_pkg::TY_F32) begin
                if (nan) return {32'd0, sgn, 31'h7FC0_0000} | {41'd0, payload[51:29]};
                if (inf) return {32'd0, sgn, 31'h7F7F_FFFF};
                return to_float(sgn, mag, e2, 1'b0);
            end
            if (nan) return {sgn, 11'h7FF, 1'b1, payload[50:0]};
            if (inf) return {sgn, 63'h7FEF_FFFF_FFFF_FFFF};
            return to_float(sgn, mag, e2, 1'b1);
        end

        if (is_flt) begin
            if (nan) return 0;
            huge = inf;
            ip   = 0;
            if (!inf && mag != 0) begin
                ex = top_bit(mag) + e2;
                if (ex >= 64) huge = 1;
                else if (e2 >= 0) ip = mag << e2;
                else if (-e2 < 64) ip = mag >> (-e2);
            end
            if (dst == sntc_pkg::TY_I8 || dst == sntc_pkg::TY_I16 ||
                dst == sntc_pkg::TY_I32 || dst == sntc_pkg::TY_I64) begin
                // Magnitudes at or beyond 2^(w-1) clip to the end of the range.
                if (huge || {1'b0, ip} >= (65'd1 << (dw - 1)))
                    return sgn ? ((64'd1 << (dw - 1)) & dmask) : (dmask >> 1);
                return (sgn ? (~ip + 64'd1) : ip) & dmask;
            end
            if (sgn) return 0;
            if (huge || {1'b0, ip} >= {1'b0, dmask} + 65'd1) return dmask;
            return ip;
        end

        if (dst == sntc_pkg::TY_I8 || dst == sntc_pkg::TY_I16 ||
            dst == sntc_pkg::TY_I32 || dst == sntc_pkg::TY_I64) begin
            smax = $signed({3'b000, dmask[63:1]});
            smin = -smax - 66'sd1;
            if (iv > smax) iv = smax;
            if (iv < smin) iv = smin;
            return iv[63:0] & dmask;
        end
        if (iv < 0) return 0;
        if (iv > $signed({2'b00, dmask})) return dmask;
        return iv[63:0];
    endfunction

    function void note_input(logic [63:0] val, logic last);
        conv_beat_t b;
        b.bits = reverse ? convert(store_ty, query_ty, val) : convert(query_ty, store_ty, val);
        b.last = last;
        awaited.push_back(b);
    endfunction

    function void check_result(logic [63:0] bits, logic last);
        conv_beat_t b;
        checked++;
        if (awaited.size() == 0) begin
            $error("result beat with nothing expected: result_bits=%h", bits);
            errors++;
            return;
        end
        b = awaited.pop_front();
        if (bits !== b.bits) begin
            $error("result_bits: expected %h, actual %h", b.bits, bits);
            errors++;
        end
        if (last !== b.last) begin
            $error("last_out: expected %b, actual %b", b.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb_top;
    import sntc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_value_bits;
    logic        s_last_in;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_bits;
    logic        m_last_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    conv_scoreboard conv_sb;
    int send_pct;
    int stall_pct;
    int hold_tickets;
    int hold_seen;
    int hold_left;
    int cycles;
    int items_sent;
    int settings_used;

    saturating_numeric_type_converter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value_bits(s_value_bits), .s_last_in(s_last_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_bits(m_result_bits), .m_last_out(m_last_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Handshakes are judged at the falling edge, where every signal is stable
    // until the rising edge that completes the beat.
    always @(negedge aclk) begin
        if (aresetn && s_valid && s_ready) conv_sb.note_input(s_value_bits, s_last_in);
        if (aresetn && m_valid && m_ready) conv_sb.check_result(m_result_bits, m_last_out);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_tickets) begin
            hold_seen = hold_tickets;
            m_ready   <= 1'b0;
            hold_left <= 60;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL saturating_numeric_type_converter");
            $finish;
        end
    end

    task automatic send_element(logic [63:0] val, logic last);
        while ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_value_bits <= val;
        s_last_in    <= last;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (conv_sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        conv_sb.set_reg(idx, data);
    endtask

    task automatic apply_types(logic [3:0] q, logic [3:0] s, logic [3:0] d);
        wait_drained();
        write_reg(CFG_QUERY, q);
        write_reg(CFG_STORE, s);
        write_reg(CFG_DIR, d);
        settings_used++;
    endtask

    // Mixes plain random patterns with range edges and awkward floats.
    function automatic logic [63:0] pick_value(logic [3:0] src);
        logic [63:0] r;
        int          w, k;
        logic [51:0] mf;
        r = {$urandom, $urandom};
        w = conv_sb.ty_bits(src);
        case ($urandom_range(9))
            0, 1: return r;
            2: return 64'd0;
            3: return '1;
            4: return r & ~conv_sb.lo_mask(w) | (64'd1 << (w - 1));
            5: return r & ~conv_sb.lo_mask(w) | (conv_sb.lo_mask(w) >> 1);
            default: begin
                case ($urandom_range(3))
                    0: mf = 0;
                    1: mf = '1;
                    2: mf = {3'($urandom_range(7)), 49'd0};
                    default: mf = r[51:0];
                endcase
                if (src == TY_F32) begin
                    case ($urandom_range(5))
                        0: k = 0;
                        1: k = 255;
                        2: k = 127 + $urandom_range(6, 8);
                        3: k = 127 + $urandom_range(14, 16);
                        4: k = 127 + $urandom_range(30, 33);
                        default: k = 127 + $urandom_range(62, 65);
                    endcase
                    return {r[63:32], r[31], 8'(k), mf[51:29]};
                end
                case ($urandom_range(7))
                    0: k = 0;
                    1: k = 2047;
                    2: k = 1023 + $urandom_range(127, 129);
                    3: k = 1023 - $urandom_range(124, 152);
                    4: k = 1023 + $urandom_range(30, 33);
                    5: k = 1023 + $urandom_range(62, 65);
                    6: k = $urandom_range(2046);
                    default: k = 1023 + $urandom_range(0, 16);
                endcase
                return {r[63], 11'(k), mf};
            end
        endcase
    endfunction

    typedef struct {
        logic [3:0]  q;
        logic [3:0]  s;
        logic [3:0]  d;
        logic [63:0] v;
    } case_t;

    initial begin
        case_t       dir_cases[$];
        logic [3:0]  cq, cs, cd, src;
        int          phase;

        conv_sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0; s_value_bits = '0; s_last_in = 1'b0;
        cfg_valid = 1'b0; cfg_index = CFG_QUERY; cfg_data = '0;
        m_ready = 1'b0;
        send_pct = 0; stall_pct = 0;
        hold_tickets = 0; hold_seen = 0; hold_left = 0;
        cycles = 0; items_sent = 0; settings_used = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_cases = '{
            '{TY_I32, TY_I32, 4'd0, 64'hFFFF_FFFF_8000_0000},
            '{TY_F64, TY_I64, 4'd0, 64'h43E0_0000_0000_0000},
            '{TY_F64, TY_I64, 4'd0, 64'hC3E0_0000_0000_0001},
            '{TY_F64, TY_I64, 4'd0, 64'h7FF0_0000_0000_0123},
            '{TY_F64, TY_U64, 4'd0, 64'h43F0_0000_0000_0000},
            '{TY_F64, TY_U64, 4'd0, 64'h43EF_FFFF_FFFF_FFFF},
            '{TY_F64, TY_U64, 4'd0, 64'hBFF8_0000_0000_0000},
            '{TY_F64, TY_F32, 4'd0, 64'hFFF0_1234_5678_9ABC},
            '{TY_F64, TY_F32, 4'd0, 64'h7E37_E43C_8800_759C},
            '{TY_F64, TY_F32, 4'd0, 64'hFFF0_0000_0000_0000},
            '{TY_F64, TY_F32, 4'd0, 64'h47EF_FFFF_F000_0000},
            '{TY_F64, TY_F32, 4'd0, 64'h36A8_0000_0000_0001},
            '{TY_F32, TY_F64, 4'd0, 64'h0000_0000_FF80_0000},
            '{TY_F32, TY_F64, 4'd0, 64'h0000_0000_7FA1_2345},
            '{TY_F32, TY_I32, 4'd0, 64'h0000_0000_CF00_0000},
            '{TY_U64, TY_F32, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF},
            '{TY_I64, TY_F64, 4'd0, 64'h8000_0000_0000_0001},
            '{TY_I8, TY_U8, 4'd0, 64'h0000_0000_0000_00FF},
            '{TY_U64, TY_I8, 4'd0, 64'h0000_0000_0000_0180},
            '{TY_I16, TY_U64, 4'd0, 64'h1234_5678_9ABC_8000},
            '{4'd12, TY_I32, 4'd0, 64'h0000_0000_0000_0055},
            '{TY_I8, TY_F64, 4'd1, 64'hC00D_9999_9999_999A},
            '{TY_U8, 4'd15, 4'd1, 64'h0000_0000_0000_0007}
        };
        foreach (dir_cases[i]) begin
            if (i > 0) apply_types(dir_cases[i].q, dir_cases[i].s, dir_cases[i].d);
            send_element(dir_cases[i].v, 1'($urandom_range(1)));
        end

        for (phase = 0; phase < 30; phase++) begin
            case (phase % 5)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 68; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 68; end
                3: begin send_pct = 30; stall_pct = 30; end
                default: begin send_pct = 0; stall_pct = 0; end
            endcase
            if (phase == 0) begin
                cq = TY_I8; cs = TY_F64; cd = 4'd0;
            end else if (phase == 1) begin
                cq = TY_F64; cs = TY_I8; cd = 4'd1;
            end else if ($urandom_range(19) == 0) begin
                cq = 4'($urandom_range(10, 15)); cs = 4'($urandom_range(9)); cd = 4'($urandom);
            end else begin
                cq = 4'($urandom_range(9)); cs = 4'($urandom_range(9)); cd = 4'($urandom);
            end
            apply_types(cq, cs, cd);
            src = cd[0] ? cs : cq;
            for (int n = 0; n < 25; n++) begin
                if (phase == 4 && n == 3) hold_tickets++;
                if (phase == 9 && n == 12) wait_drained();
                send_element(pick_value(src), 1'($urandom_range(1)));
            end
        end

        wait_drained();
        $display("Converted %0d elements under %0d type settings, both directions.",
                 items_sent, settings_used);
        $display("Result beats checked: %0d, mismatches: %0d.", conv_sb.checked, conv_sb.errors);
        if (conv_sb.errors == 0) begin
            $display("PASS saturating_numeric_type_converter");
        end else begin
            $display("FAIL saturating_numeric_type_converter");
        end
        $finish;
    end
endmodule
